// ===== rtl/y2rp_pkg.sv =====
// ----------------------------------------------------------------------------
// y2rp_pkg: shared types and constants of the 4:2:2 to RGB pair converter
// Item structs, register map, Q16 coefficients and the channel clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package y2rp_pkg;

    // Register map: one register, byte address is 4 times the index.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_BYTE_ORDER = 1'b0;

    // Fixed point setup.
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned ACC_W     = 27;

    localparam logic signed [ACC_W-1:0] COEF_RV = 27'sd92242;
    localparam logic signed [ACC_W-1:0] COEF_GU = 27'sd22643;
    localparam logic signed [ACC_W-1:0] COEF_GV = 27'sd46983;
    localparam logic signed [ACC_W-1:0] COEF_BU = 27'sd116589;
    localparam logic [8:0] CHROMA_MID = 9'd128;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       last_group;
    } y2rp_in_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       last_pair;
    } y2rp_out_t;

    // Floor by dropping the fraction, then clamp to 0..255.
    function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1]) begin
            res = 8'd0;
        end else if (|acc[ACC_W-2:FRAC_BITS+8]) begin
            res = 8'd255;
        end else begin
            res = acc[FRAC_BITS+7:FRAC_BITS];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/y2rp_apb_regs.sv =====
// ----------------------------------------------------------------------------
// y2rp_apb_regs: configuration register file
// Holds the byte order register behind a simple APB slave.
// ----------------------------------------------------------------------------
`default_nettype none

module y2rp_apb_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [y2rp_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [y2rp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [y2rp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output logic      [1:0]                        byte_order
);
    import y2rp_pkg::*;

    logic [1:0]            byte_order_reg;
    logic [1:0]            byte_order_next;
    logic [APB_ADDR_W-3:0] reg_index;
    logic                  wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb begin
        byte_order_next = byte_order_reg;
        if (wr_en && (reg_index == REG_BYTE_ORDER)) begin
            byte_order_next = pwdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg <= 2'd0;
        end else begin
            byte_order_reg <= byte_order_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_BYTE_ORDER) begin
            prdata = {{(APB_DATA_W-2){1'b0}}, byte_order_reg};
        end
    end

    assign byte_order = byte_order_reg;

endmodule

`default_nettype wire

// ===== rtl/y2rp_convert.sv =====
// ----------------------------------------------------------------------------
// y2rp_convert: byte unpacking and color matrix for one group
// Picks Y0, Y1, U and V, forms the shared chroma products and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module y2rp_convert (
    input  wire logic                 [1:0] byte_order,
    input  wire y2rp_pkg::y2rp_in_t         in_item,
    output y2rp_pkg::y2rp_out_t             out_item
);
    import y2rp_pkg::*;

    logic [7:0]              y_first;
    logic [7:0]              y_second;
    logic [7:0]              u_byte;
    logic [7:0]              v_byte;
    logic signed [8:0]       du;
    logic signed [8:0]       dv;
    logic signed [ACC_W-1:0] du_ext;
    logic signed [ACC_W-1:0] dv_ext;
    logic signed [ACC_W-1:0] term_r;
    logic signed [ACC_W-1:0] term_g;
    logic signed [ACC_W-1:0] term_b;
    logic signed [ACC_W-1:0] yq_first;
    logic signed [ACC_W-1:0] yq_second;

    // Bit 0 swaps the two lumas, bit 1 swaps the chroma bytes.
    assign y_first  = byte_order[0] ? in_item.byte2 : in_item.byte0;
    assign y_second = byte_order[0] ? in_item.byte0 : in_item.byte2;
    assign u_byte   = byte_order[1] ? in_item.byte3 : in_item.byte1;
    assign v_byte   = byte_order[1] ? in_item.byte1 : in_item.byte3;

    assign du     = $signed({1'b0, u_byte} - CHROMA_MID);
    assign dv     = $signed({1'b0, v_byte} - CHROMA_MID);
    assign du_ext = ACC_W'(du);
    assign dv_ext = ACC_W'(dv);

    // Chroma terms are common to both pixels of the pair.
    assign term_r = COEF_RV * dv_ext;
    assign term_g = (COEF_GU * du_ext) + (COEF_GV * dv_ext);
    assign term_b = COEF_BU * du_ext;

    assign yq_first  = $signed({{(ACC_W-FRAC_BITS-8){1'b0}}, y_first,  {FRAC_BITS{1'b0}}});
    assign yq_second = $signed({{(ACC_W-FRAC_BITS-8){1'b0}}, y_second, {FRAC_BITS{1'b0}}});

    always_comb begin
        out_item.red_first    = clamp_channel(yq_first + term_r);
        out_item.green_first  = clamp_channel(yq_first - term_g);
        out_item.blue_first   = clamp_channel(yq_first + term_b);
        out_item.red_second   = clamp_channel(yq_second + term_r);
        out_item.green_second = clamp_channel(yq_second - term_g);
        out_item.blue_second  = clamp_channel(yq_second + term_b);
        out_item.last_pair    = in_item.last_group;
    end

endmodule

`default_nettype wire

// ===== rtl/yuv422_to_rgb_pair.sv =====
// ----------------------------------------------------------------------------
// yuv422_to_rgb_pair: packed 4:2:2 group to two RGB888 pixels
// Input register, color matrix, result register, with an APB config port.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                     Moves
//   --------  ------------------------  ---------------------------------
//   input     s_valid s_ready s_data    one packed group of four bytes
//   result    m_valid m_ready m_data    one pair of RGB888 pixels
//   config    APB psel..pready          byte_order register at address 0
//
// An item is held first in the input register and then in the result
// register, with the color matrix in between.
// One item is accepted per clock as long as the result side keeps taking.
// Reset (synchronous, active low) empties both stages and sets byte order 0.
// A stall at the result side holds the result; the input register still
// fills, so one more item is taken before s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv422_to_rgb_pair (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Input channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire y2rp_pkg::y2rp_in_t                s_data,
    // Result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output y2rp_pkg::y2rp_out_t                    m_data,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [y2rp_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [y2rp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [y2rp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import y2rp_pkg::*;

    logic      [1:0] byte_order;

    // Input stage registers.
    logic            in_valid_reg;
    logic            in_valid_next;
    y2rp_in_t        in_data_reg;

    // Result stage registers.
    logic            out_valid_reg;
    logic            out_valid_next;
    y2rp_out_t       out_data_reg;

    y2rp_out_t       conv_item;
    logic            out_ready;
    logic            in_take;
    logic            out_load;

    y2rp_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_order (byte_order)
    );

    y2rp_convert u_convert (
        .byte_order (byte_order),
        .in_item    (in_data_reg),
        .out_item   (conv_item)
    );

    // The result register can load when it is empty or its item is leaving.
    // The input register can load when it is empty or its item moves on.
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign in_take   = s_valid && s_ready;
    assign out_load  = in_valid_reg && out_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_data_reg <= s_data;
        end
        if (out_load) begin
            out_data_reg <= conv_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 4:2:2 to RGB pair converter
// Drives packed groups with random gaps, applies back-pressure on the
// result side, and checks every pixel pair against a Q16 color model kept
// in the bench, under each byte order programmed over APB.
// ----------------------------------------------------------------------------
module tb_top;
    import y2rp_pkg::*;

    // Byte order settings. Bit 0 swaps the two lumas and bit 1 swaps U and V.
    typedef enum logic [1:0] {
        ORD_Y0UY1V = 2'd0,
        ORD_Y1UY0V = 2'd1,
        ORD_Y0VY1U = 2'd2,
        ORD_Y1VY0U = 2'd3
    } byte_order_e;

    localparam int SWAP_LUMA_BIT   = 0;
    localparam int SWAP_CHROMA_BIT = 1;

    // APB byte addresses. Only the first one holds a register.
    localparam logic [APB_ADDR_W-1:0] ADDR_BYTE_ORDER = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    // Q16 coefficients of the color matrix and the chroma offset.
    localparam longint Q16_R_FROM_V = 92242;
    localparam longint Q16_G_FROM_U = 22643;
    localparam longint Q16_G_FROM_V = 46983;
    localparam longint Q16_B_FROM_U = 116589;
    localparam longint CHROMA_ZERO  = 128;

    localparam int GROUPS_PER_PHASE = 200;
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 8;

    logic aclk;
    logic aresetn;

    logic      s_valid;
    logic      s_ready;
    y2rp_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    y2rp_out_t m_data;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    yuv422_to_rgb_pair i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Groups waiting to be driven, and the pixel pairs the block owes us.
    y2rp_in_t    groups_to_send[$];
    y2rp_out_t   pairs_owed[$];
    byte_order_e order_model;

    int unsigned groups_queued;
    int unsigned groups_taken;
    int unsigned pairs_checked;
    int unsigned mismatches;
    int unsigned stall_cycles;
    int unsigned orders_run;
    bit          group_fired;
    bit          hold_sender;
    bit          calm;

    // ------------------------------------------------------------------
    // Color model. Y sits at Q16, the chroma products are added exactly,
    // and the sum is floored by an arithmetic shift and clamped to a byte.
    // A negative sum clamps to zero before the shift.
    // ------------------------------------------------------------------
    function automatic logic [7:0] clamp_q16(longint acc);
        longint whole;
        if (acc < 0) begin
            return 8'd0;
        end
        whole = acc >>> 16;
        if (whole > 255) begin
            return 8'd255;
        end
        return whole[7:0];
    endfunction

    function automatic logic [23:0] pixel_rgb(longint luma, longint cb, longint cr);
        longint yq;
        longint du;
        longint dv;
        yq = luma <<< 16;
        du = cb - CHROMA_ZERO;
        dv = cr - CHROMA_ZERO;
        return {clamp_q16(yq + Q16_R_FROM_V * dv),
                clamp_q16(yq - Q16_G_FROM_U * du - Q16_G_FROM_V * dv),
                clamp_q16(yq + Q16_B_FROM_U * du)};
    endfunction

    function automatic y2rp_out_t convert_group(y2rp_in_t grp, byte_order_e order);
        logic [7:0]  luma_a;
        logic [7:0]  luma_b;
        logic [7:0]  cb;
        logic [7:0]  cr;
        y2rp_out_t   pair;
        luma_a = order[SWAP_LUMA_BIT]   ? grp.byte2 : grp.byte0;
        luma_b = order[SWAP_LUMA_BIT]   ? grp.byte0 : grp.byte2;
        cb     = order[SWAP_CHROMA_BIT] ? grp.byte3 : grp.byte1;
        cr     = order[SWAP_CHROMA_BIT] ? grp.byte1 : grp.byte3;
        {pair.red_first, pair.green_first, pair.blue_first} =
            pixel_rgb(longint'(luma_a), longint'(cb), longint'(cr));
        {pair.red_second, pair.green_second, pair.blue_second} =
            pixel_rgb(longint'(luma_b), longint'(cb), longint'(cr));
        pair.last_pair = grp.last_group;
        return pair;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // APB access. Signals change on the falling edge; with pready tied
    // high the access phase completes at the next rising edge.
    // ------------------------------------------------------------------
    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes the byte order, updates the model, and reads the register back.
    task automatic program_byte_order(byte_order_e order);
        logic [APB_DATA_W-1:0] readback;
        apb_write(ADDR_BYTE_ORDER, APB_DATA_W'(order));
        order_model = order;
        orders_run++;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BYTE_ORDER;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("byte_order readback", APB_DATA_W'(order), readback);
    endtask

    // Blocks until every queued group has gone in and every pair came out.
    // The block always answers a group, so once the last pair is back
    // both stages are empty and the register may be changed.
    task automatic wait_until_idle();
        wait (groups_taken == groups_queued && pairs_owed.size() == 0);
        @(negedge aclk);
    endtask

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Group driver. A new group goes out only once the previous one was
    // taken at the last rising edge; otherwise valid and data are held.
    // Gaps are random, except in the calm stretch and while the sender is
    // held back to let the block drain.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || group_fired) begin
            if (groups_to_send.size() > 0 && !hold_sender &&
                (calm || $urandom_range(99) >= 23)) begin
                s_valid <= 1'b1;
                s_data  <= groups_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random too, and not at all in the calm stretch.
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 23);
    end

    // ------------------------------------------------------------------
    // Monitor. Sampling on the rising edge sees the values from before the
    // edge. An accepted group adds its predicted pair to the back of the
    // owed queue; an accepted pair is checked against the front.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        y2rp_out_t want;
        group_fired = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (group_fired) begin
                pairs_owed.push_back(convert_group(s_data, order_model));
                groups_taken++;
            end
            if (m_valid && m_ready) begin
                if (pairs_owed.size() == 0) begin
                    $error("pixel pair arrived with none outstanding");
                    mismatches++;
                end else begin
                    want = pairs_owed.pop_front();
                    check_field("red_first",    want.red_first,    m_data.red_first);
                    check_field("green_first",  want.green_first,  m_data.green_first);
                    check_field("blue_first",   want.blue_first,   m_data.blue_first);
                    check_field("red_second",   want.red_second,   m_data.red_second);
                    check_field("green_second", want.green_second, m_data.green_second);
                    check_field("blue_second",  want.blue_second,  m_data.blue_second);
                    check_field("last_pair",    want.last_pair,    m_data.last_pair);
                    pairs_checked++;
                end
            end
            if (group_fired || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Watchdog: ends the run if no item moves for too long.
    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("No item moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [7:0]  corner_bytes[4];
        byte_order_e phase_orders[7];
        y2rp_in_t    grp;
        logic [7:0]  mid_lo;
        int unsigned drain_point;

        corner_bytes = '{8'd0, 8'd1, 8'd254, 8'd255};
        phase_orders = '{ORD_Y0UY1V, ORD_Y1UY0V, ORD_Y0VY1U, ORD_Y1VY0U,
                         ORD_Y1VY0U, ORD_Y0UY1V, ORD_Y1UY0V};

        // Every input is at a known level before the first edge.
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        order_model   = ORD_Y0UY1V;
        groups_queued = 0;
        groups_taken  = 0;
        pairs_checked = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        orders_run    = 1;
        group_fired   = 1'b0;
        hold_sender   = 1'b0;
        calm          = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed groups under the reset byte order. All combinations of
        // full-scale bytes drive every channel into both clamps; the
        // neutral-chroma groups check that Y passes straight through; two have V at 127.
        for (int k = 0; k < 16; k++) begin
            grp.byte0      = k[0] ? 8'd255 : 8'd0;
            grp.byte1      = k[1] ? 8'd255 : 8'd0;
            grp.byte2      = k[2] ? 8'd255 : 8'd0;
            grp.byte3      = k[3] ? 8'd255 : 8'd0;
            grp.last_group = k[0] ^ k[3];
            groups_to_send.push_back(grp);
            groups_queued++;
        end
        for (int k = 0; k < 4; k++) begin
            grp.byte0      = corner_bytes[k];
            grp.byte1      = 8'd128;
            grp.byte2      = corner_bytes[3 - k];
            grp.byte3      = (k < 2) ? 8'd128 : 8'd127;
            grp.last_group = k[0];
            groups_to_send.push_back(grp);
            groups_queued++;
        end
        wait_until_idle();

        // Random phases, one byte order each. The fifth phase also writes an
        // unmapped address, which must leave the byte order as it was.
        for (int ph = 0; ph < 7; ph++) begin
            program_byte_order(phase_orders[ph]);
            if (ph == 4) begin
                apb_write(ADDR_UNMAPPED, $urandom);
            end
            for (int n = 0; n < GROUPS_PER_PHASE; n++) begin
                case ($urandom_range(9))
                    0, 1: begin
                        // Chroma close to neutral, where the floor matters most.
                        mid_lo         = 8'(120 + $urandom_range(16));
                        grp            = y2rp_in_t'($urandom);
                        grp.byte1      = mid_lo;
                        grp.byte3      = 8'(120 + $urandom_range(16));
                    end
                    2: begin
                        grp.byte0      = corner_bytes[$urandom_range(3)];
                        grp.byte1      = corner_bytes[$urandom_range(3)];
                        grp.byte2      = corner_bytes[$urandom_range(3)];
                        grp.byte3      = corner_bytes[$urandom_range(3)];
                    end
                    default: begin
                        grp            = y2rp_in_t'({$urandom, 1'b0});
                    end
                endcase
                grp.last_group = ($urandom_range(7) == 0);
                groups_to_send.push_back(grp);
                groups_queued++;
            end

            // A stretch with no gaps on either side in the middle of the run.
            if (ph == 3) begin
                calm = 1'b1;
            end

            // In the second phase the sender stops halfway and waits until
            // the block has handed back everything it owes.
            if (ph == 1) begin
                drain_point = groups_queued - GROUPS_PER_PHASE / 2;
                wait (groups_taken >= drain_point);
                hold_sender = 1'b1;
                wait (groups_taken == groups_queued - groups_to_send.size() &&
                      pairs_owed.size() == 0);
                @(negedge aclk);
                hold_sender = 1'b0;
            end

            wait_until_idle();
            calm = 1'b0;
        end

        // Let any stray result show up before the final verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pairs_owed.size() != 0) begin
            $error("%0d pixel pairs never arrived", pairs_owed.size());
            mismatches++;
        end

        $display("Sent %0d packed groups under %0d byte-order settings, including clamp corners.",
                 groups_taken, orders_run);
        $display("Checked %0d pixel pairs field by field; %0d mismatches.",
                 pairs_checked, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/y2rp_pkg.sv
rtl/y2rp_apb_regs.sv
rtl/y2rp_convert.sv
rtl/yuv422_to_rgb_pair.sv
bench/tb_top.sv
